FILE: hdl/lpht_pkg.sv
// Shared types, codes and constants of the linear probing hash table core.
`timescale 1ns / 1ps

package lpht_pkg;

  localparam int KEY_W     = 32;
  localparam int VALUE_W   = 32;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int ENTRIES_W = 7;
  localparam int FILL_W    = 6;

  localparam logic [FILL_W-1:0] FILL_RESET = 6'd48;
  localparam logic [63:0]       HASH_SEED  = 64'd5381;

  // Request operations
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef enum logic [1:0] {
    WR_INSERT    = 2'd0,
    WR_FREE_TAG  = 2'd1,
    WR_FREE_WALK = 2'd2,
    WR_CLEAR     = 2'd3
  } wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_t;

  typedef struct packed {
    logic                load_req;
    logic                hash_start;
    logic                hash_from_ram;
    logic                load_home;
    logic                rd_probe;
    logic                n_inc;
    logic                rd_walk;
    logic                walk_init;
    logic                walk_adv;
    logic                load_move;
    logic                wr_en;
    wr_sel_t             wr_sel;
    cnt_op_t             cnt_op;
    logic                finish;
    logic [STATUS_W-1:0] res_status;
    logic                take_value;
  } dp_cmd_t;

  typedef struct packed {
    logic hash_done;
    logic q_used;
    logic q_key_eq;
    logic n_last;
    logic w_full;
    logic fill_reached;
    logic clr_last;
  } dp_sts_t;

endpackage

FILE: hdl/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/lpht_hash.sv
// Home slot unit: djb2 hash of the key bytes reduced modulo the capacity.
`timescale 1ns / 1ps

module lpht_hash #(
  parameter int CAPACITY  = 64,
  parameter int KEY_BYTES = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lpht_pkg::KEY_W-1:0]    key,
  output logic                          done,
  output logic [$clog2(CAPACITY)-1:0]   home
);

  localparam int SlotW    = $clog2(CAPACITY);
  localparam bit IsPow2   = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam int ByteCntW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int HashW    = 64;
  // Partial hash before reduction: remainder * 33 + byte, remainder below the capacity
  localparam int AccW     = SlotW + 9;
  localparam int Shift    = AccW + SlotW;
  localparam int RecipW   = AccW + 2;
  localparam int ProdW    = AccW + RecipW;
  localparam logic [HashW-1:0]  Seed    = lpht_pkg::HASH_SEED;
  localparam logic [SlotW-1:0]  SeedRem = SlotW'(lpht_pkg::HASH_SEED % 64'(CAPACITY));
  localparam logic [AccW-1:0]   CapX    = AccW'(CAPACITY);
  // Rounded-up reciprocal: exact quotient for every AccW-bit dividend
  localparam logic [RecipW-1:0] Recip   =
    RecipW'(((64'd1 << Shift) + 64'(CAPACITY) - 64'd1) / 64'(CAPACITY));

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_BYTE = 4'b0010,
    H_QUOT = 4'b0100,
    H_REM  = 4'b1000
  } hstate_t;

  hstate_t                      st_r;
  logic                         done_r;
  logic [SlotW-1:0]             home_r;
  logic [SlotW-1:0]             rem_r;
  logic [AccW-1:0]              acc_r;
  logic [AccW-1:0]              quo_r;
  logic [lpht_pkg::KEY_W-1:0]   kbuf_r;
  logic [ByteCntW-1:0]          bcnt_r;
  logic [HashW-1:0]             key_ext;
  logic [SlotW-1:0]             lo_hash;
  logic [ProdW-1:0]             prod;
  logic [AccW-1:0]              rem_full;
  logic [SlotW-1:0]             rem_nxt;

  assign key_ext = HashW'(key);

  // Low bits of the hash only need low-bit arithmetic when the capacity is a power of two
  always_comb begin
    logic [SlotW-1:0] lo;
    lo = Seed[SlotW-1:0];
    for (int i = 0; i < KEY_BYTES; i++) begin
      lo = (lo << 5) + lo + SlotW'(key_ext[8*i +: 8]);
    end
    lo_hash = lo;
  end

  // Otherwise keep the hash reduced after every byte; the full hash never wraps
  assign prod     = ProdW'(acc_r) * ProdW'(Recip);
  assign rem_full = acc_r - quo_r * CapX;
  assign rem_nxt  = rem_full[SlotW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= H_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        H_IDLE: begin
          if (start) begin
            if (IsPow2) begin
              done_r <= 1'b1;
            end else begin
              st_r <= H_BYTE;
            end
          end
        end
        H_BYTE: st_r <= H_QUOT;
        H_QUOT: st_r <= H_REM;
        H_REM: begin
          if (bcnt_r == ByteCntW'(KEY_BYTES - 1)) begin
            done_r <= 1'b1;
            st_r   <= H_IDLE;
          end else begin
            st_r <= H_BYTE;
          end
        end
        default: st_r <= H_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      H_IDLE: begin
        if (start) begin
          home_r <= lo_hash;
          rem_r  <= SeedRem;
          kbuf_r <= key;
          bcnt_r <= '0;
        end
      end
      H_BYTE: begin
        acc_r <= (AccW'(rem_r) << 5) + AccW'(rem_r) + AccW'(kbuf_r[7:0]);
      end
      H_QUOT: begin
        quo_r <= AccW'(prod >> Shift);
      end
      H_REM: begin
        rem_r  <= rem_nxt;
        home_r <= rem_nxt;
        kbuf_r <= kbuf_r >> 8;
        bcnt_r <= bcnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign home = home_r;

endmodule

FILE: hdl/lpht_dp.sv
// Datapath: slot store, probe and walk pointers, entry count and result registers.
`timescale 1ns / 1ps

module lpht_dp #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BYTES  = 4,
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [lpht_pkg::KEY_W-1:0]        in_key,
  input  logic [lpht_pkg::VALUE_W-1:0]      in_value,
  input  logic                              cfg_we,
  input  logic [lpht_pkg::FILL_W-1:0]       cfg_wdata,
  input  lpht_pkg::dp_cmd_t                 cmd,
  output lpht_pkg::dp_sts_t                 sts,
  output logic [lpht_pkg::STATUS_W-1:0]     out_status,
  output logic [lpht_pkg::VALUE_W-1:0]      out_value_out,
  output logic [lpht_pkg::ENTRIES_W-1:0]    out_entries
);

  localparam int SlotW = $clog2(CAPACITY);
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int KeyW  = lpht_pkg::KEY_W;
  localparam int WordW = 1 + KeyW + VALUE_BITS;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(CAPACITY - 1);

  function automatic logic [SlotW-1:0] step_slot(input logic [SlotW-1:0] s);
    step_slot = (s == LastSlot) ? '0 : s + 1'b1;
  endfunction

  logic [KeyW-1:0]                    tkey_r;
  logic [VALUE_BITS-1:0]              tval_r;
  logic [SlotW-1:0]                   s_r;
  logic [SlotW-1:0]                   tag_r;
  logic [SlotW-1:0]                   n_r;
  logic [SlotW-1:0]                   j_r;
  logic [CntW-1:0]                    w_r;
  logic [SlotW-1:0]                   clr_r;
  logic [lpht_pkg::ENTRIES_W-1:0]     count_r;
  logic [lpht_pkg::ENTRIES_W-1:0]     count_nxt;
  logic [lpht_pkg::FILL_W-1:0]        fill_r;
  logic [lpht_pkg::STATUS_W-1:0]      status_r;
  logic [lpht_pkg::VALUE_W-1:0]       vout_r;
  logic [lpht_pkg::ENTRIES_W-1:0]     entries_r;

  logic                               ram_we;
  logic [SlotW-1:0]                   ram_waddr;
  logic [WordW-1:0]                   ram_wdata;
  logic [SlotW-1:0]                   ram_raddr;
  logic [WordW-1:0]                   q_word;
  logic                               q_used;
  logic [KeyW-1:0]                    q_key;
  logic [VALUE_BITS-1:0]              q_val;
  logic [63:0]                        q_val_ext;
  logic [63:0]                        in_val_ext;
  logic                               hash_done;
  logic [SlotW-1:0]                   hash_home;

  assign q_used     = q_word[WordW-1];
  assign q_key      = q_word[VALUE_BITS +: KeyW];
  assign q_val      = q_word[VALUE_BITS-1:0];
  assign q_val_ext  = 64'(q_val);
  assign in_val_ext = 64'(in_value);

  lpht_hash #(
    .CAPACITY  (CAPACITY),
    .KEY_BYTES (KEY_BYTES)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.hash_start),
    .key   (cmd.hash_from_ram ? q_key : in_key),
    .done  (hash_done),
    .home  (hash_home)
  );

  lpht_ram #(
    .WIDTH (WordW),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (q_word)
  );

  assign ram_raddr = cmd.rd_walk ? j_r : s_r;
  assign ram_we    = cmd.wr_en;

  always_comb begin
    ram_waddr = tag_r;
    ram_wdata = '0;
    case (cmd.wr_sel)
      lpht_pkg::WR_INSERT: begin
        ram_waddr = tag_r;
        ram_wdata = {1'b1, tkey_r, tval_r};
      end
      lpht_pkg::WR_FREE_TAG:  ram_waddr = tag_r;
      lpht_pkg::WR_FREE_WALK: ram_waddr = j_r;
      lpht_pkg::WR_CLEAR:     ram_waddr = clr_r;
      default:                ram_waddr = tag_r;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      lpht_pkg::CNT_INC: count_nxt = count_r + 1'b1;
      lpht_pkg::CNT_DEC: count_nxt = count_r - 1'b1;
      default:           count_nxt = count_r;
    endcase
  end

  // Control state: count, fill limit, clearing sweep pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      fill_r  <= lpht_pkg::FILL_RESET;
      clr_r   <= '0;
    end else begin
      count_r <= count_nxt;
      if (cfg_we) begin
        fill_r <= cfg_wdata;
      end
      if (cmd.wr_en && (cmd.wr_sel == lpht_pkg::WR_CLEAR)) begin
        clr_r <= step_slot(clr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      tkey_r <= in_key;
      tval_r <= in_val_ext[VALUE_BITS-1:0];
    end else if (cmd.load_move) begin
      tkey_r <= q_key;
      tval_r <= q_val;
    end
    if (cmd.load_home) begin
      s_r <= hash_home;
      n_r <= '0;
    end else begin
      if (cmd.rd_probe) begin
        tag_r <= s_r;
        s_r   <= step_slot(s_r);
      end
      if (cmd.n_inc) begin
        n_r <= n_r + 1'b1;
      end
    end
    if (cmd.walk_init) begin
      j_r <= step_slot(tag_r);
      w_r <= '0;
    end else if (cmd.walk_adv) begin
      j_r <= step_slot(j_r);
      w_r <= w_r + 1'b1;
    end
    if (cmd.finish) begin
      status_r  <= cmd.res_status;
      vout_r    <= cmd.take_value ? q_val_ext[lpht_pkg::VALUE_W-1:0] : '0;
      entries_r <= count_nxt;
    end
  end

  assign sts.hash_done    = hash_done;
  assign sts.q_used       = q_used;
  assign sts.q_key_eq     = (q_key == tkey_r);
  assign sts.n_last       = (n_r == LastSlot);
  assign sts.w_full       = (w_r == CntW'(CAPACITY));
  assign sts.fill_reached = (count_r >= {1'b0, fill_r});
  assign sts.clr_last     = (clr_r == LastSlot);

  assign out_status    = status_r;
  assign out_value_out = vout_r;
  assign out_entries   = entries_r;

endmodule

FILE: hdl/lpht_ctrl.sv
// Controller: sequences clearing, probing, removal walk and reinsertion.
`timescale 1ns / 1ps

module lpht_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lpht_pkg::CMD_W-1:0]    in_cmd,
  input  lpht_pkg::dp_sts_t             sts,
  output lpht_pkg::dp_cmd_t             cmd,
  output logic                          busy,
  output logic                          out_strobe
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_HASH   = 10'b00_0000_0100,
    S_ISSUE  = 10'b00_0000_1000,
    S_PROBE  = 10'b00_0001_0000,
    S_WISSUE = 10'b00_0010_0000,
    S_WCHK   = 10'b00_0100_0000,
    S_RHASH  = 10'b00_1000_0000,
    S_RISSUE = 10'b01_0000_0000,
    S_RPROBE = 10'b10_0000_0000
  } state_t;

  state_t                       st_r, st_nxt;
  logic                         strobe_r;
  logic [lpht_pkg::CMD_W-1:0]   op_r;

  always_comb begin
    st_nxt = st_r;
    cmd    = '0;
    unique case (st_r)
      S_CLEAR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = lpht_pkg::WR_CLEAR;
        if (sts.clr_last) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          if (in_cmd == lpht_pkg::CMD_NONE) begin
            cmd.finish     = 1'b1;
            cmd.res_status = lpht_pkg::ST_OK;
          end else begin
            cmd.hash_start = 1'b1;
            st_nxt         = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (sts.hash_done) begin
          cmd.load_home = 1'b1;
          st_nxt        = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.rd_probe = 1'b1;
        st_nxt       = S_PROBE;
      end
      S_PROBE: begin
        unique case (op_r)
          lpht_pkg::CMD_LOOKUP: begin
            if (!sts.q_used || sts.n_last || sts.q_key_eq) begin
              cmd.finish     = 1'b1;
              cmd.res_status = (sts.q_used && sts.q_key_eq) ? lpht_pkg::ST_OK
                                                            : lpht_pkg::ST_MISSING;
              cmd.take_value = sts.q_used && sts.q_key_eq;
              st_nxt         = S_IDLE;
            end else begin
              cmd.rd_probe = 1'b1;
              cmd.n_inc    = 1'b1;
            end
          end
          lpht_pkg::CMD_INSERT: begin
            if (!sts.q_used) begin
              cmd.finish = 1'b1;
              st_nxt     = S_IDLE;
              if (sts.fill_reached) begin
                cmd.res_status = lpht_pkg::ST_FULL;
              end else begin
                cmd.res_status = lpht_pkg::ST_OK;
                cmd.wr_en      = 1'b1;
                cmd.wr_sel     = lpht_pkg::WR_INSERT;
                cmd.cnt_op     = lpht_pkg::CNT_INC;
              end
            end else if (sts.q_key_eq) begin
              cmd.finish     = 1'b1;
              cmd.res_status = lpht_pkg::ST_OK;
              cmd.wr_en      = 1'b1;
              cmd.wr_sel     = lpht_pkg::WR_INSERT;
              st_nxt         = S_IDLE;
            end else if (sts.n_last) begin
              cmd.finish     = 1'b1;
              cmd.res_status = lpht_pkg::ST_FULL;
              st_nxt         = S_IDLE;
            end else begin
              cmd.rd_probe = 1'b1;
              cmd.n_inc    = 1'b1;
            end
          end
          lpht_pkg::CMD_REMOVE: begin
            if (sts.q_used && sts.q_key_eq) begin
              cmd.wr_en     = 1'b1;
              cmd.wr_sel    = lpht_pkg::WR_FREE_TAG;
              cmd.cnt_op    = lpht_pkg::CNT_DEC;
              cmd.walk_init = 1'b1;
              st_nxt        = S_WISSUE;
            end else if (!sts.q_used || sts.n_last) begin
              cmd.finish     = 1'b1;
              cmd.res_status = lpht_pkg::ST_MISSING;
              st_nxt         = S_IDLE;
            end else begin
              cmd.rd_probe = 1'b1;
              cmd.n_inc    = 1'b1;
            end
          end
          default: begin
            cmd.finish     = 1'b1;
            cmd.res_status = lpht_pkg::ST_OK;
            st_nxt         = S_IDLE;
          end
        endcase
      end
      S_WISSUE: begin
        cmd.rd_walk = 1'b1;
        st_nxt      = S_WCHK;
      end
      S_WCHK: begin
        if (sts.w_full || !sts.q_used) begin
          cmd.finish     = 1'b1;
          cmd.res_status = lpht_pkg::ST_OK;
          st_nxt         = S_IDLE;
        end else begin
          cmd.load_move     = 1'b1;
          cmd.wr_en         = 1'b1;
          cmd.wr_sel        = lpht_pkg::WR_FREE_WALK;
          cmd.cnt_op        = lpht_pkg::CNT_DEC;
          cmd.hash_start    = 1'b1;
          cmd.hash_from_ram = 1'b1;
          st_nxt            = S_RHASH;
        end
      end
      S_RHASH: begin
        if (sts.hash_done) begin
          cmd.load_home = 1'b1;
          st_nxt        = S_RISSUE;
        end
      end
      S_RISSUE: begin
        cmd.rd_probe = 1'b1;
        st_nxt       = S_RPROBE;
      end
      S_RPROBE: begin
        if (!sts.q_used || sts.q_key_eq) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = lpht_pkg::WR_INSERT;
          cmd.cnt_op   = sts.q_used ? lpht_pkg::CNT_HOLD : lpht_pkg::CNT_INC;
          cmd.walk_adv = 1'b1;
          st_nxt       = S_WISSUE;
        end else if (sts.n_last) begin
          cmd.walk_adv = 1'b1;
          st_nxt       = S_WISSUE;
        end else begin
          cmd.rd_probe = 1'b1;
          cmd.n_inc    = 1'b1;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_CLEAR;
      strobe_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      strobe_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r <= in_cmd;
    end
  end

  assign busy       = (st_r != S_IDLE);
  assign out_strobe = strobe_r;

endmodule

FILE: hdl/linear_probe_hash_table_core.sv
// Top level of the linear probing hash table core: controller plus datapath.
`timescale 1ns / 1ps

// Key/value hash table with open addressing and linear probing. A request
// (in_cmd, in_key, in_value) is taken on a clock edge with start high and busy
// low; its single result appears on out_status, out_value_out and out_entries
// for exactly one cycle with out_strobe high, and cannot be held off, so
// capture it in that cycle. A new request may be issued in the strobe cycle.
// After reset the core runs a clearing pass over every slot of the slot
// store with busy high; fill_limit writes through cfg_we/cfg_wdata are taken
// at any time. Lookup and insert first find the home slot, straight from the
// low hash bits when CAPACITY is a power of two and otherwise per key byte
// by multiply-add, quotient by reciprocal multiplication and remainder, then
// probe slot by slot. A removal that hits rehashes and reprobes every
// following entry it moves, and stops on reading the closing empty slot.
// Probing reads the slot store through its single read port, one slot a
// cycle.
module linear_probe_hash_table_core #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BYTES  = 4,
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  logic [lpht_pkg::CMD_W-1:0]        in_cmd,
  input  logic [lpht_pkg::KEY_W-1:0]        in_key,
  input  logic [lpht_pkg::VALUE_W-1:0]      in_value,
  // fill limit register
  input  logic                              cfg_we,
  input  logic [lpht_pkg::FILL_W-1:0]       cfg_wdata,
  // result channel
  output logic                              out_strobe,
  output logic [lpht_pkg::STATUS_W-1:0]     out_status,
  output logic [lpht_pkg::VALUE_W-1:0]      out_value_out,
  output logic [lpht_pkg::ENTRIES_W-1:0]    out_entries
);

  // Commands from the controller, status back from the datapath
  lpht_pkg::dp_cmd_t dp_cmd;
  lpht_pkg::dp_sts_t dp_sts;

  // Controller: clears the store, walks probe chains, runs the removal walk
  // with reinsertion of each displaced entry, and raises the result strobe.
  lpht_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_cmd     (in_cmd),
    .sts        (dp_sts),
    .cmd        (dp_cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // Datapath: slot RAM holding {used, key, value}, hash unit, pointers,
  // entry count, fill limit and the result registers.
  lpht_dp #(
    .CAPACITY   (CAPACITY),
    .KEY_BYTES  (KEY_BYTES),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_key        (in_key),
    .in_value      (in_value),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (dp_cmd),
    .sts           (dp_sts),
    .out_status    (out_status),
    .out_value_out (out_value_out),
    .out_entries   (out_entries)
  );

endmodule

FILE: tb/lpht_checker.sv
// Request and reply checker for the linear probing hash table core.
`timescale 1ns / 1ps

module lpht_checker
  import lpht_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [KEY_W-1:0]     in_key,
  input  logic [VALUE_W-1:0]   in_value,
  input  logic                 cfg_we,
  input  logic [FILL_W-1:0]    cfg_wdata,
  input  logic                 out_strobe,
  input  logic [STATUS_W-1:0]  out_status,
  input  logic [VALUE_W-1:0]   out_value_out,
  input  logic [ENTRIES_W-1:0] out_entries,
  output int unsigned          pending_replies,
  output int unsigned          fault_count
);

  localparam int SLOTS        = 64;
  localparam int SLOT_W       = 6;
  localparam int HASHED_BYTES = 4;
  localparam int PRINT_CAP    = 40;

  typedef struct {
    int unsigned          req_no;
    logic [STATUS_W-1:0]  status;
    logic [VALUE_W-1:0]   value_out;
    logic [ENTRIES_W-1:0] entries;
  } table_reply_t;

  logic [KEY_W-1:0]   slot_key_m  [SLOTS];
  logic [VALUE_W-1:0] slot_val_m  [SLOTS];
  bit                 slot_used_m [SLOTS];
  int unsigned        live_entries;
  logic [FILL_W-1:0]  fill_limit_m;
  int unsigned        req_count;
  table_reply_t       reply_queue [$];

  initial begin
    fault_count     = 0;
    pending_replies = 0;
  end

  task automatic flag_fault(input string msg);
    fault_count++;
    if (fault_count <= PRINT_CAP) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // djb2 over the low key bytes, least significant first; capacity is 64
  function automatic logic [SLOT_W-1:0] home_of(input logic [KEY_W-1:0] key);
    logic [63:0] h;
    int b;
    h = HASH_SEED;
    for (b = 0; b < HASHED_BYTES; b++) h = (h << 5) + h + 64'(key[8*b +: 8]);
    return h[SLOT_W-1:0];
  endfunction

  function automatic bit locate_key(input logic [KEY_W-1:0] key,
                                    output logic [SLOT_W-1:0] at);
    logic [SLOT_W-1:0] s;
    int n;
    s  = home_of(key);
    at = '0;
    for (n = 0; n < SLOTS; n++) begin
      if (!slot_used_m[s]) return 1'b0;
      if (slot_key_m[s] == key) begin
        at = s;
        return 1'b1;
      end
      s = s + 1'b1;
    end
    return 1'b0;
  endfunction

  // First slot from home that is free or already holds the key
  function automatic bit slot_for(input logic [KEY_W-1:0] key,
                                  output logic [SLOT_W-1:0] at);
    logic [SLOT_W-1:0] s;
    int n;
    s  = home_of(key);
    at = '0;
    for (n = 0; n < SLOTS; n++) begin
      if (!slot_used_m[s] || slot_key_m[s] == key) begin
        at = s;
        return 1'b1;
      end
      s = s + 1'b1;
    end
    return 1'b0;
  endfunction

  // Reinsert a moved entry; no fill check applies here
  function automatic void replace_entry(input logic [KEY_W-1:0] key,
                                        input logic [VALUE_W-1:0] val);
    logic [SLOT_W-1:0] s;
    if (!slot_for(key, s)) return;
    slot_key_m[s] = key;
    slot_val_m[s] = val;
    if (!slot_used_m[s]) begin
      slot_used_m[s] = 1'b1;
      live_entries++;
    end
  endfunction

  function automatic void apply_request(input  logic [CMD_W-1:0]    cmd,
                                        input  logic [KEY_W-1:0]    key,
                                        input  logic [VALUE_W-1:0]  value,
                                        output logic [STATUS_W-1:0] status,
                                        output logic [VALUE_W-1:0]  vout);
    logic [SLOT_W-1:0]  at;
    logic [KEY_W-1:0]   mk;
    logic [VALUE_W-1:0] mv;
    int steps;
    status = ST_OK;
    vout   = '0;
    case (cmd)
      CMD_LOOKUP: begin
        if (locate_key(key, at)) vout = slot_val_m[at];
        else status = ST_MISSING;
      end
      CMD_INSERT: begin
        if (!slot_for(key, at)) status = ST_FULL;
        else if (slot_used_m[at]) slot_val_m[at] = value;
        else if (live_entries >= fill_limit_m) status = ST_FULL;
        else begin
          slot_key_m[at]  = key;
          slot_val_m[at]  = value;
          slot_used_m[at] = 1'b1;
          live_entries++;
        end
      end
      CMD_REMOVE: begin
        if (!locate_key(key, at)) status = ST_MISSING;
        else begin
          slot_used_m[at] = 1'b0;
          live_entries--;
          at = at + 1'b1;
          // pull each following entry out and put it back so chains stay whole
          for (steps = 0; steps < SLOTS && slot_used_m[at]; steps++) begin
            mk = slot_key_m[at];
            mv = slot_val_m[at];
            slot_used_m[at] = 1'b0;
            live_entries--;
            replace_entry(mk, mv);
            at = at + 1'b1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    table_reply_t        want;
    logic [STATUS_W-1:0] st;
    logic [VALUE_W-1:0]  vo;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_used_m[i] = 1'b0;
      live_entries = 0;
      fill_limit_m = FILL_RESET;
      req_count    = 0;
      reply_queue.delete();
    end else begin
      if ($isunknown(out_strobe)) begin
        flag_fault("result strobe unknown");
      end else if (out_strobe) begin
        if (reply_queue.size() == 0) begin
          flag_fault("reply with no request outstanding");
        end else begin
          want = reply_queue.pop_front();
          if (out_status !== want.status)
            flag_fault($sformatf("request %0d status %0d, expected %0d",
                                 want.req_no, out_status, want.status));
          if (out_value_out !== want.value_out)
            flag_fault($sformatf("request %0d value_out %h, expected %h",
                                 want.req_no, out_value_out, want.value_out));
          if (out_entries !== want.entries)
            flag_fault($sformatf("request %0d entries %0d, expected %0d",
                                 want.req_no, out_entries, want.entries));
        end
      end
      if (cfg_we) fill_limit_m = cfg_wdata;
      if (start && !busy) begin
        apply_request(in_cmd, in_key, in_value, st, vo);
        want.req_no    = req_count;
        want.status    = st;
        want.value_out = vo;
        want.entries   = ENTRIES_W'(live_entries);
        req_count++;
        reply_queue.push_back(want);
      end
    end
    pending_replies <= reply_queue.size();
  end

endmodule

FILE: tb/testbench.sv
// Top of the hash table testbench: stimulus, stall watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
  import lpht_pkg::*;

  // A removal in a nearly full table moves up to 62 entries, each probing up
  // to 64 slots; allow several times that with no request or reply moving.
  localparam int STALL_LIMIT = 30000;
  localparam int TAIL_CYCLES = 100;
  localparam int POOL_MAX    = 80;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [CMD_W-1:0]     in_cmd;
  logic [KEY_W-1:0]     in_key;
  logic [VALUE_W-1:0]   in_value;
  logic                 cfg_we;
  logic [FILL_W-1:0]    cfg_wdata;
  logic                 out_strobe;
  logic [STATUS_W-1:0]  out_status;
  logic [VALUE_W-1:0]   out_value_out;
  logic [ENTRIES_W-1:0] out_entries;

  int unsigned          pending_replies;
  int unsigned          fault_count;
  int unsigned          idle_cycles = 0;

  // Keys already offered for insertion; drawn again to hit stored entries
  logic [KEY_W-1:0]     key_pool [$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  linear_probe_hash_table_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_key        (in_key),
    .in_value      (in_value),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_value_out (out_value_out),
    .out_entries   (out_entries)
  );

  lpht_checker i_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .in_value        (in_value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_value_out   (out_value_out),
    .out_entries     (out_entries),
    .pending_replies (pending_replies),
    .fault_count     (fault_count)
  );

  // Present one request at the falling edge and hold it until a rising edge
  // finds busy low. Start is left high so a following request runs back to
  // back; the caller lowers it through pause_sender.
  task automatic send_request(input logic [CMD_W-1:0]   cmd,
                              input logic [KEY_W-1:0]   key,
                              input logic [VALUE_W-1:0] value);
    @(negedge clk);
    start    = 1'b1;
    in_cmd   = cmd;
    in_key   = key;
    in_value = value;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drop start and scramble the idle fields for a gap of the given length.
  task automatic pause_sender(input int unsigned cycles);
    @(negedge clk);
    start    = 1'b0;
    in_cmd   = CMD_W'($urandom());
    in_key   = $urandom();
    in_value = $urandom();
    repeat (cycles) @(posedge clk);
  endtask

  // Drain every outstanding reply, then write the fill limit while idle.
  task automatic retune(input logic [FILL_W-1:0] limit);
    pause_sender(0);
    do @(posedge clk); while (pending_replies != 0);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = limit;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = FILL_W'($urandom());
  endtask

  // Mostly revisit known keys; otherwise make a key from a colliding family
  // (equal low six bits in each byte share a home slot, a step in the top
  // byte moves it by one) or a fresh random key.
  function automatic logic [KEY_W-1:0] pick_key(output bit pooled);
    logic [KEY_W-1:0] family [4] = '{32'h05050505, 32'h06050505,
                                     32'h07050505, 32'h3F3F3F3F};
    int unsigned roll;
    roll   = $urandom_range(0, 99);
    pooled = 1'b0;
    if (roll < 55 && key_pool.size() != 0) begin
      pooled = 1'b1;
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    end
    if (roll < 78) return ($urandom() & 32'hC0C0C0C0) | family[$urandom_range(0, 3)];
    return $urandom();
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input int unsigned ins_pct,
                                                 input int unsigned rem_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) return CMD_INSERT;
    if (roll < ins_pct + rem_pct) return CMD_REMOVE;
    if (roll < 97) return CMD_LOOKUP;
    return CMD_NONE;
  endfunction

  // Random requests in bursts of random length; about a quarter of bursts
  // follow on with no gap at all.
  task automatic run_random_phase(input int unsigned items,
                                  input int unsigned ins_pct,
                                  input int unsigned rem_pct);
    int unsigned      left;
    int unsigned      burst;
    logic [KEY_W-1:0] key;
    logic [CMD_W-1:0] cmd;
    bit               pooled;
    left = items;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) begin
        key = pick_key(pooled);
        cmd = pick_cmd(ins_pct, rem_pct);
        if (cmd == CMD_INSERT && !pooled) begin
          key_pool.push_back(key);
          if (key_pool.size() > POOL_MAX) void'(key_pool.pop_front());
        end
        send_request(cmd, key, $urandom());
      end
      left -= burst;
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(0, 15));
    end
  endtask

  // Abort if neither a request nor a reply has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    start     = 1'b0;
    in_cmd    = CMD_LOOKUP;
    in_key    = '0;
    in_value  = '0;
    cfg_we    = 1'b0;
    cfg_wdata = FILL_RESET;
    rst_n     = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: small fill limit so the full refusal comes quickly
    retune(6'd4);
    send_request(CMD_LOOKUP, 32'h00000000, 32'h00000000);  // empty table
    send_request(CMD_REMOVE, 32'h00000000, 32'hFFFFFFFF);  // absent key
    send_request(CMD_INSERT, 32'h00000005, 32'h00000000);  // three share a home
    send_request(CMD_INSERT, 32'h40000005, 32'hFFFFFFFF);
    send_request(CMD_INSERT, 32'h80000005, 32'h5A5A5A5A);
    send_request(CMD_INSERT, 32'hFFFFFFFF, 32'hA5A5A5A5);  // reaches the limit
    send_request(CMD_INSERT, 32'h00000000, 32'h11111111);  // new key refused
    send_request(CMD_INSERT, 32'h80000005, 32'h12345678);  // update at the limit
    send_request(CMD_LOOKUP, 32'h80000005, 32'h00000000);
    send_request(CMD_REMOVE, 32'h00000005, 32'h00000000);  // head of chain: rehash
    send_request(CMD_LOOKUP, 32'h40000005, 32'h00000000);
    send_request(CMD_LOOKUP, 32'h80000005, 32'h00000000);
    send_request(CMD_LOOKUP, 32'h00000005, 32'h00000000);
    send_request(CMD_NONE,   32'h40000005, 32'hFFFFFFFF);  // unused operation
    send_request(CMD_REMOVE, 32'h40000005, 32'h00000000);
    send_request(CMD_REMOVE, 32'h80000005, 32'h00000000);

    // Zero fill limit: new keys refused, present key still updated
    retune(6'd0);
    send_request(CMD_INSERT, 32'h00000001, 32'h00000001);
    send_request(CMD_INSERT, 32'hFFFFFFFF, 32'h00000000);
    send_request(CMD_LOOKUP, 32'hFFFFFFFF, 32'h00000000);
    send_request(CMD_REMOVE, 32'hFFFFFFFF, 32'h00000000);
    send_request(CMD_LOOKUP, 32'h00000001, 32'h00000000);

    // Random: fill to the top limit, churn the full table, then squeeze
    retune(6'd63);
    run_random_phase(250, 60, 15);
    run_random_phase(150, 35, 30);
    retune(6'd1);
    run_random_phase(120, 50, 20);
    retune(6'd0);
    run_random_phase(100, 50, 30);
    retune(FILL_RESET);
    run_random_phase(200, 45, 25);
    retune(6'd20);
    run_random_phase(200, 45, 30);
    repeat (6) begin
      retune(FILL_W'($urandom_range(0, 63)));
      run_random_phase(80, 45, 30);
    end

    // Drain, then give any stray reply time to show
    pause_sender(0);
    do @(posedge clk); while (pending_replies != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
